FILE: design/prs_pkg.sv
package prs_pkg;

    localparam int DATA_W    = 32;
    localparam int MAX_LEVEL = 10;
    localparam int ROW_DEPTH = (1 << MAX_LEVEL) + 1;
    localparam int CNT_W     = MAX_LEVEL + 1;
    localparam int IDX_W     = 10;
    localparam int LVL_W     = 4;
    localparam int INV_W     = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = INV_W;
    localparam int SUM_W     = DATA_W + 3;
    localparam int DIGIT_W   = 8;
    localparam int N_CELLS   = INV_W / DIGIT_W;
    localparam int PROD_W    = SUM_W + INV_W;
    localparam int FRAC_W    = 8;
    localparam int QV_W      = DATA_W + 1;
    localparam int RES_W     = DATA_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H2     = 1'b1;

    localparam logic [LVL_W-1:0] LEVEL_RESET = 4'd1;
    localparam logic [INV_W-1:0] INV_RESET   = 40'd256;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             done;
    } t_tag;

    typedef struct packed {
        t_tag                     tag;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] south;
        logic signed [DATA_W-1:0] west;
        logic signed [DATA_W-1:0] east;
        logic signed [DATA_W-1:0] center;
        logic signed [DATA_W-1:0] f;
    } t_stencil;

    typedef struct packed {
        t_tag                     tag;
        logic                     neg;
        logic signed [DATA_W-1:0] f;
        logic [SUM_W-1:0]         mag;
        logic [PROD_W-1:0]        acc;
    } t_cell;

    // Grid side for a level, with the level clamped to 1..MAX_LEVEL.
    function automatic logic [CNT_W-1:0] side_len(input logic [LVL_W-1:0] level);
        logic [LVL_W-1:0] l;
        l = level;
        if (l == '0) begin
            l = LVL_W'(1);
        end else if (l > LVL_W'(MAX_LEVEL)) begin
            l = LVL_W'(MAX_LEVEL);
        end
        return (CNT_W'(1) << l) + CNT_W'(1);
    endfunction

endpackage

FILE: design/prs_line_buf.sv
module prs_line_buf import prs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_accept,
    input  logic                     i_restart,
    input  logic [CNT_W-1:0]         i_side,
    input  logic signed [DATA_W-1:0] i_sol,
    input  logic signed [DATA_W-1:0] i_src,
    output t_stencil                 o_st
);

    logic [DATA_W-1:0] r_up_mem  [ROW_DEPTH];
    logic [DATA_W-1:0] r_mid_mem [ROW_DEPTH];
    logic [DATA_W-1:0] r_src_mem [ROW_DEPTH];

    logic [CNT_W-1:0]  r_row, r_col, n_row, n_col;
    logic [DATA_W-1:0] r_mid_ahead, r_west, r_west_q, r_north, r_south, r_center, r_f;
    logic              r_tag_valid, r_tag_done;
    logic [IDX_W-1:0]  r_tag_row, r_tag_col;
    logic [CNT_W-1:0]  w_ahead;
    logic              w_interior, w_done;

    // The middle row is read one column ahead; at the row's end it wraps to column 0,
    // which already holds the row just finished.
    assign w_ahead = (r_col == i_side - CNT_W'(1)) ? '0 : r_col + CNT_W'(1);

    assign w_interior = (r_row >= CNT_W'(2)) && (r_col >= CNT_W'(1))
                     && (r_col + CNT_W'(2) <= i_side);
    assign w_done     = (r_row + CNT_W'(1) == i_side) && (r_col + CNT_W'(2) == i_side);

    always_comb begin
        n_col = r_col + CNT_W'(1);
        n_row = r_row;
        if (n_col >= i_side) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
            if (n_row >= i_side) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_north           <= r_up_mem[r_col];
            r_up_mem[r_col]   <= r_mid_ahead;
            r_mid_ahead       <= r_mid_mem[w_ahead];
            r_mid_mem[r_col]  <= i_sol;
            r_f               <= r_src_mem[r_col];
            r_src_mem[r_col]  <= i_src;
            r_south           <= i_sol;
            r_center          <= r_mid_ahead;
            r_west_q          <= r_west;
            r_west            <= r_mid_ahead;
            r_tag_row         <= IDX_W'(r_row - CNT_W'(1));
            r_tag_col         <= IDX_W'(r_col);
            r_tag_done        <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_tag_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_adv) begin
                r_tag_valid <= i_accept && w_interior;
            end
        end
    end

    // The east neighbour is the look-ahead word itself, loaded on this same acceptance.
    always_comb begin
        o_st.tag.valid = r_tag_valid;
        o_st.tag.row   = r_tag_row;
        o_st.tag.col   = r_tag_col;
        o_st.tag.done  = r_tag_done;
        o_st.north     = r_north;
        o_st.south     = r_south;
        o_st.west      = r_west_q;
        o_st.east      = r_mid_ahead;
        o_st.center    = r_center;
        o_st.f         = r_f;
    end

endmodule

FILE: design/prs_mac_cell.sv
module prs_mac_cell import prs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [DIGIT_W-1:0] i_digit,
    input  t_cell              i_cell,
    output t_cell              o_cell
);

    logic [SUM_W+DIGIT_W-1:0] w_pp;
    t_cell                    n_cell, r_cell;

    // One byte of the reciprocal per cell, most significant first (Horner form).
    always_comb begin
        w_pp       = i_cell.mag * i_digit;
        n_cell     = i_cell;
        n_cell.acc = (i_cell.acc << DIGIT_W) + PROD_W'(w_pp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.tag.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: design/poisson_residual_stencil.sv
// Five-point Laplacian residual over a square grid streamed in row-major order.
// Input channel: i_in_valid / o_in_stall carry one grid point per word, a solution
// value and a source value, both signed Q16.16. Output channel: o_out_valid /
// i_out_stall carry one residual word for each interior point, with its row and
// column, a saturation flag and a flag on the last residual of the grid.
// The configuration port writes grid_level (index 0, restarts the grid) and inv_h2
// (index 1, Q32.8); write them only while no word is in flight.
// One word is taken every cycle while o_in_stall is low. A residual follows from the
// word of the point below it: the line buffers are read into registers on the
// accepting edge, then the stencil sum, the magnitude, the five cells of the
// multiplier chain (one reciprocal byte a cell) and the rounding and saturation into
// the output register are each registered in turn.
// When the output word is held by i_out_stall, the whole pipeline holds and
// o_in_stall rises; it falls again as soon as the output word is taken.
// Reset clears the counters and pipeline valid bits and sets level 1 and inv_h2 256.
// The line buffers are not cleared; the streaming order fills each entry before use.
module poisson_residual_stencil import prs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [DATA_W-1:0]  i_sol_value,
    input  logic signed [DATA_W-1:0]  i_source_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DATA_W-1:0]  o_residual_value,
    output logic [IDX_W-1:0]          o_res_row,
    output logic [IDX_W-1:0]          o_res_col,
    output logic                      o_grid_done,
    output logic                      o_saturated
);

    logic [LVL_W-1:0]         r_grid_level;
    logic [INV_W-1:0]         r_inv_h2;
    logic                     w_adv, w_accept, w_restart;
    t_stencil                 w_st;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    t_tag                     r_sum_tag;
    logic signed [DATA_W-1:0] r_sum_f;
    t_cell                    r_head, n_head;
    t_cell                    w_chain [N_CELLS+1];
    t_cell                    w_last;

    logic                     w_frac, w_big, w_ovf;
    logic [QV_W:0]            w_q;
    logic signed [RES_W-1:0]  w_res, w_f_s, w_q_s, w_frac_s;
    logic [DATA_W-1:0]        w_res_sat;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_res;
    t_tag                     r_out_tag;
    logic                     r_out_sat;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;
    assign w_restart  = i_cfg_wr_en && (i_cfg_index == CFG_GRID_LEVEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_level <= LEVEL_RESET;
            r_inv_h2     <= INV_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_GRID_LEVEL) begin
                r_grid_level <= i_cfg_data[LVL_W-1:0];
            end else if (i_cfg_index == CFG_INV_H2) begin
                r_inv_h2 <= i_cfg_data[INV_W-1:0];
            end
        end
    end

    prs_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_accept  (w_accept),
        .i_restart (w_restart),
        .i_side    (side_len(r_grid_level)),
        .i_sol     (i_sol_value),
        .i_src     (i_source_value),
        .o_st      (w_st)
    );

    assign n_sum = SUM_W'(w_st.north) + SUM_W'(w_st.south) + SUM_W'(w_st.west)
                 + SUM_W'(w_st.east) - (SUM_W'(w_st.center) <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_sum     <= n_sum;
            r_sum_tag <= w_st.tag;
            r_sum_f   <= w_st.f;
        end
    end

    always_comb begin
        n_head.tag = r_sum_tag;
        n_head.neg = r_sum[SUM_W-1];
        n_head.f   = r_sum_f;
        n_head.mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        n_head.acc = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        prs_mac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_digit (r_inv_h2[DIGIT_W*(N_CELLS-1-k) +: DIGIT_W]),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    assign w_last = w_chain[N_CELLS];

    // A quotient of 2^(DATA_W+1) or more saturates whatever the source, so it is
    // capped there. A negative sum rounds toward minus infinity, hence the extra one
    // when fraction bits are lost.
    always_comb begin
        w_frac   = |w_last.acc[FRAC_W-1:0];
        w_big    = |w_last.acc[PROD_W-1:FRAC_W+QV_W];
        w_q      = w_big ? {1'b1, {QV_W{1'b0}}}
                         : {1'b0, w_last.acc[FRAC_W+QV_W-1:FRAC_W]};
        w_f_s    = RES_W'(w_last.f);
        w_q_s    = RES_W'($signed({1'b0, w_q}));
        w_frac_s = $signed({{(RES_W-1){1'b0}}, w_frac});
        w_res    = w_last.neg ? (w_f_s - w_q_s - w_frac_s) : (w_f_s + w_q_s);
        w_ovf    = !((&w_res[RES_W-1:DATA_W-1]) || !(|w_res[RES_W-1:DATA_W-1]));
        if (w_ovf) begin
            w_res_sat = w_res[RES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_res_sat = w_res[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.tag.valid;
            r_out_res   <= w_res_sat;
            r_out_tag   <= w_last.tag;
            r_out_sat   <= w_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_residual_value = r_out_res;
    assign o_res_row        = r_out_tag.row;
    assign o_res_col        = r_out_tag.col;
    assign o_grid_done      = r_out_tag.done;
    assign o_saturated      = r_out_sat;

endmodule
